### rtl/ubpca_pkg.sv
// Package for the utilization bin-packing core assigner.
// Holds request and result types, policy codes, the sequencer states and constants.
// Depends on nothing.
package ubpca_pkg;

    localparam int CORE_CNT_DEF = 4;
    localparam int LOAD_W = 16;
    localparam int SUM_W = LOAD_W + 1;
    localparam logic [SUM_W-1:0] LOAD_ONE = SUM_W'(32768);

    typedef enum logic [1:0] {
        POL_FIRST = 2'd0,
        POL_BEST  = 2'd1,
        POL_WORST = 2'd2
    } t_policy;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE
    } t_state;

    typedef struct packed {
        logic              mode;
        logic [LOAD_W-1:0] task_load;
    } t_req;

    typedef struct packed {
        logic [2:0]        core_index;
        logic              placed;
        logic [LOAD_W-1:0] core_load_after;
    } t_res;

endpackage

### rtl/ubpca_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
module ubpca_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/utilization_bin_packing_core_assigner.sv
// Top level of the utilization bin-packing core assigner.
// Uses ubpca_pkg and the generic RAM ubpca_ram that holds the core loads.
//
// A request is taken at a rising edge with start high and busy low. A clear
// request empties every core; its all-zero result follows in the next cycle and
// the block is ready again at once. A place request scans the core loads in
// the RAM, one read per cycle, compares each sum against 1.0 and keeps the
// pick of the current policy; then the write state writes the chosen load back
// if a core fit. busy stays high through the scan and the write-back. The
// result is shown on o_res for one cycle with o_res_strobe after the
// write-back; the receiver cannot stall and always takes it.
// The policy register is written over the cfg channel, which is always ready
// and must only be used while the block is idle. Reset clears the policy to
// first-fit, marks every core load empty through per-core valid bits and
// returns the sequencer to idle; no clearing pass is needed.
module utilization_bin_packing_core_assigner
    import ubpca_pkg::*;
#(
    parameter int NUM_CORES = CORE_CNT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_req       i_req,
    output logic       o_res_strobe,
    output t_res       o_res,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_data
);

    localparam int IdxW = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
    localparam int CntW = $clog2(NUM_CORES + 1);

    t_state              r_state, n_state;
    logic [CntW-1:0]     r_rd_cnt, n_rd_cnt;
    logic                r_pend, n_pend;
    logic [IdxW-1:0]     r_pend_idx, n_pend_idx;
    logic                r_have, n_have;
    logic [LOAD_W-1:0]   r_best, n_best;
    logic [IdxW-1:0]     r_chosen, n_chosen;
    logic [LOAD_W-1:0]   r_task, n_task;
    logic [NUM_CORES-1:0] r_valid, n_valid;
    logic [1:0]          r_policy;
    logic                r_strobe, n_strobe;
    t_res                r_res, n_res;

    logic                ram_we;
    logic [LOAD_W-1:0]   ram_rdata;
    logic [LOAD_W-1:0]   cur_load;
    logic [SUM_W-1:0]    cur_sum;
    logic                cur_fit;
    logic                cur_take;
    logic                accept;

    ubpca_ram #(
        .WIDTH (LOAD_W),
        .DEPTH (NUM_CORES)
    ) u_load_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_chosen),
        .i_wdata (r_best),
        .i_raddr (r_rd_cnt[IdxW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign accept = start && !busy;
    assign busy = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_res_strobe = r_strobe;
    assign o_res = r_res;

    assign cur_load = r_valid[r_pend_idx] ? ram_rdata : '0;
    assign cur_sum = {1'b0, cur_load} + {1'b0, r_task};
    assign cur_fit = (cur_sum <= LOAD_ONE);
    assign cur_take = r_pend && cur_fit && (!r_have
        || (r_policy == POL_BEST && cur_sum[LOAD_W-1:0] > r_best)
        || (r_policy == POL_WORST && cur_sum[LOAD_W-1:0] < r_best));

    always_comb begin
        n_state = r_state;
        n_rd_cnt = r_rd_cnt;
        n_pend = 1'b0;
        n_pend_idx = r_pend_idx;
        n_have = r_have;
        n_best = r_best;
        n_chosen = r_chosen;
        n_task = r_task;
        n_valid = r_valid;
        n_strobe = 1'b0;
        n_res = r_res;
        ram_we = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_req.mode) begin
                        n_valid = '0;
                        n_strobe = 1'b1;
                        n_res = '0;
                    end else begin
                        n_state = ST_SCAN;
                        n_rd_cnt = '0;
                        n_have = 1'b0;
                        n_best = '0;
                        n_chosen = '0;
                        n_task = i_req.task_load;
                    end
                end
            end
            ST_SCAN: begin
                if (r_rd_cnt < CntW'(NUM_CORES)) begin
                    n_pend = 1'b1;
                    n_pend_idx = r_rd_cnt[IdxW-1:0];
                    n_rd_cnt = r_rd_cnt + CntW'(1);
                end
                if (cur_take) begin
                    n_have = 1'b1;
                    n_best = cur_sum[LOAD_W-1:0];
                    n_chosen = r_pend_idx;
                end
                if (r_pend && r_pend_idx == IdxW'(NUM_CORES - 1)) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                ram_we = r_have;
                if (r_have) begin
                    n_valid[r_chosen] = 1'b1;
                end
                n_strobe = 1'b1;
                n_res.core_index = r_have ? 3'(r_chosen) : 3'd0;
                n_res.placed = r_have;
                n_res.core_load_after = r_have ? r_best : '0;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pend <= 1'b0;
            r_valid <= '0;
            r_policy <= POL_FIRST;
            r_strobe <= 1'b0;
            r_rd_cnt <= '0;
            r_have <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend <= n_pend;
            r_valid <= n_valid;
            r_strobe <= n_strobe;
            r_rd_cnt <= n_rd_cnt;
            r_have <= n_have;
            if (i_cfg_valid && o_cfg_ready) begin
                r_policy <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_idx <= n_pend_idx;
        r_best <= n_best;
        r_chosen <= n_chosen;
        r_task <= n_task;
        r_res <= n_res;
    end

    a_scan_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> !r_strobe)
        else $error("result shown while a scan is running");

    a_unplaced_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && !r_res.placed) |-> (r_res.core_index == 3'd0
        && r_res.core_load_after == '0))
        else $error("unplaced result carries nonzero fields");

    a_load_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_res.placed) |-> ({1'b0, r_res.core_load_after} <= LOAD_ONE))
        else $error("placed load exceeds one");

    a_write_then_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WRITE) |=> (r_strobe && r_state == ST_IDLE))
        else $error("write-back not followed by a result");

endmodule

### sim/tb_utilization_bin_packing_core_assigner.sv
// Self-checking testbench for the utilization bin-packing core assigner.
// Predicts every result with its own core-load model and compares all fields.
// Depends on ubpca_pkg and utilization_bin_packing_core_assigner.
`timescale 1ns / 100ps

module tb_utilization_bin_packing_core_assigner;
    import ubpca_pkg::*;

    localparam int CORE_CNT = CORE_CNT_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic MODE_PLACE = 1'b0;
    localparam logic MODE_CLEAR = 1'b1;
    localparam logic [1:0] POL_UNUSED = 2'd3;
    localparam logic [LOAD_W-1:0] LOAD_FULL = LOAD_W'(32768);

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_req       i_req;
    logic       o_res_strobe;
    t_res       o_res;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_data;

    logic [LOAD_W-1:0] model_load [CORE_CNT];
    logic [1:0]        model_policy;
    t_res              pending_results [$];
    int                error_count;
    int                cycle_count;
    bit                gaps_on;

    utilization_bin_packing_core_assigner #(
        .NUM_CORES(CORE_CNT)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_res_strobe(o_res_strobe),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_res predict_assignment(input t_req req);
        t_res              res;
        logic [SUM_W-1:0]  sum;
        logic [SUM_W-1:0]  best_sum;
        int                chosen;
        res = '0;
        chosen = -1;
        best_sum = '0;
        if (req.mode == MODE_CLEAR) begin
            foreach (model_load[c]) model_load[c] = '0;
            return res;
        end
        for (int c = 0; c < CORE_CNT; c++) begin
            sum = SUM_W'(model_load[c]) + SUM_W'(req.task_load);
            if (sum > LOAD_ONE) continue;
            if (chosen < 0) begin
                chosen = c;
                best_sum = sum;
                if (model_policy != POL_BEST && model_policy != POL_WORST) break;
            end else if (model_policy == POL_BEST && sum > best_sum) begin
                chosen = c;
                best_sum = sum;
            end else if (model_policy == POL_WORST && sum < best_sum) begin
                chosen = c;
                best_sum = sum;
            end
        end
        if (chosen >= 0) begin
            model_load[chosen] = best_sum[LOAD_W-1:0];
            res.core_index = 3'(chosen);
            res.placed = 1'b1;
            res.core_load_after = best_sum[LOAD_W-1:0];
        end
        return res;
    endfunction

    function automatic logic [LOAD_W-1:0] random_task_load();
        logic [LOAD_W-1:0] load;
        case ($urandom_range(0, 15))
            0: load = '0;
            1: load = LOAD_FULL;
            2: load = LOAD_W'($urandom_range(32769, 65535));
            3: load = LOAD_W'($urandom());
            4, 5: load = LOAD_FULL - model_load[$urandom_range(0, CORE_CNT - 1)];
            6: load = LOAD_W'($urandom_range(16384, 32767));
            default: load = LOAD_W'($urandom_range(1, 12000));
        endcase
        return load;
    endfunction

    task automatic send_request(input logic mode, input logic [LOAD_W-1:0] load);
        t_req req;
        req.mode = mode;
        req.task_load = load;
        if (gaps_on && $urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        start = 1'b1;
        i_req = req;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        pending_results.push_back(predict_assignment(req));
        @(negedge i_clk);
        start = 1'b0;
    endtask

    task automatic wait_idle();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (CORE_CNT + 3) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_policy(input logic [1:0] policy);
        wait_idle();
        i_cfg_valid = 1'b1;
        i_cfg_data = policy;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        model_policy = policy;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        i_cfg_data = 2'($urandom_range(0, 3));
    endtask

    task automatic send_random_request();
        if ($urandom_range(0, 24) == 0) begin
            send_request(MODE_CLEAR, LOAD_W'($urandom()));
        end else begin
            send_request(MODE_PLACE, random_task_load());
        end
    endtask

    task automatic test_directed_cases();
        gaps_on = 1'b0;
        send_request(MODE_PLACE, '0);
        send_request(MODE_PLACE, LOAD_FULL);
        send_request(MODE_PLACE, LOAD_FULL);
        send_request(MODE_PLACE, LOAD_W'(1));
        send_request(MODE_PLACE, '1);
        send_request(MODE_PLACE, LOAD_W'(32769));
        send_request(MODE_PLACE, LOAD_W'(32767));
        send_request(MODE_PLACE, '0);
        send_request(MODE_CLEAR, '1);
        write_policy(POL_BEST);
        send_request(MODE_PLACE, LOAD_W'(10000));
        send_request(MODE_PLACE, LOAD_W'(5000));
        send_request(MODE_PLACE, '0);
        send_request(MODE_PLACE, LOAD_W'(17768));
        send_request(MODE_PLACE, LOAD_W'(40000));
        write_policy(POL_WORST);
        send_request(MODE_PLACE, '0);
        send_request(MODE_PLACE, LOAD_W'(20000));
        send_request(MODE_PLACE, LOAD_W'(12768));
        write_policy(POL_UNUSED);
        send_request(MODE_PLACE, LOAD_W'(1));
        send_request(MODE_PLACE, LOAD_W'(32768 - 20000));
        send_request(MODE_CLEAR, '0);
        send_request(MODE_PLACE, LOAD_W'(21845));
    endtask

    task automatic test_policy_phases();
        logic [1:0] order [5] = '{POL_FIRST, POL_BEST, POL_WORST, POL_UNUSED, POL_BEST};
        gaps_on = 1'b1;
        foreach (order[p]) begin
            write_policy(order[p]);
            repeat (280) send_random_request();
        end
    endtask

    task automatic test_back_to_back();
        gaps_on = 1'b0;
        write_policy(POL_WORST);
        repeat (150) send_random_request();
        write_policy(POL_FIRST);
        repeat (150) send_random_request();
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_res_strobe) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result core_index=%0d placed=%0b load=%0d",
                         $time, o_res.core_index, o_res.placed, o_res.core_load_after);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_res.core_index !== want.core_index) begin
                    $display("%0t: core_index expected %0d actual %0d",
                             $time, want.core_index, o_res.core_index);
                    error_count++;
                end
                if (o_res.placed !== want.placed) begin
                    $display("%0t: placed expected %0b actual %0b",
                             $time, want.placed, o_res.placed);
                    error_count++;
                end
                if (o_res.core_load_after !== want.core_load_after) begin
                    $display("%0t: core_load_after expected %0d actual %0d",
                             $time, want.core_load_after, o_res.core_load_after);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_utilization_bin_packing_core_assigner: errors");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_req = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        error_count = 0;
        cycle_count = 0;
        gaps_on = 1'b0;
        model_policy = POL_FIRST;
        foreach (model_load[c]) model_load[c] = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_cases();
        test_policy_phases();
        test_back_to_back();

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4 * CORE_CNT) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("tb_utilization_bin_packing_core_assigner: clean");
        end else begin
            $display("tb_utilization_bin_packing_core_assigner: errors");
        end
        $finish;
    end

endmodule
